// ===== hw/rtl/complex_divide_unit_defines.svh =====
// Assertion macros for the complex divide unit.
`ifndef COMPLEX_DIVIDE_UNIT_DEFINES_SVH
`define COMPLEX_DIVIDE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CDU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("cdu check failed");
`define CDU_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("cdu check failed");
`else
`define CDU_ASSERT(lbl, clk, rst, prop)
`define CDU_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== hw/rtl/cdu_pkg.sv =====
// Shared constants of the complex divide unit.
package cdu_pkg;
   localparam logic [1:0] CDU_STATUS_OK   = 2'd0;
   localparam logic [1:0] CDU_STATUS_OVF  = 2'd1;
   localparam logic [1:0] CDU_STATUS_DIVZ = 2'd2;
   localparam int unsigned CDU_QUEUE_DEPTH = 4;
endpackage

// ===== hw/rtl/cdu_req_if.sv =====
// Request channel carrying a dividend and a divisor.
interface cdu_req_if #(parameter int WIDTH = 16);
   logic valid;
   logic ready;
   logic signed [WIDTH-1:0] dividend_real;
   logic signed [WIDTH-1:0] dividend_imag;
   logic signed [WIDTH-1:0] divisor_real;
   logic signed [WIDTH-1:0] divisor_imag;
   modport source (output valid, dividend_real, dividend_imag, divisor_real, divisor_imag,
                   input ready);
   modport sink (input valid, dividend_real, dividend_imag, divisor_real, divisor_imag,
                 output ready);
endinterface

// ===== hw/rtl/cdu_rsp_if.sv =====
// Response channel carrying a quotient and its status.
interface cdu_rsp_if #(parameter int WIDTH = 16);
   logic valid;
   logic ready;
   logic signed [WIDTH-1:0] quotient_real;
   logic signed [WIDTH-1:0] quotient_imag;
   logic [1:0] status;
   modport source (output valid, quotient_real, quotient_imag, status, input ready);
   modport sink (input valid, quotient_real, quotient_imag, status, output ready);
endinterface

// ===== hw/rtl/cdu_front.sv =====
// Front end: products, conjugate sums, magnitudes and zero-divisor detection.
module cdu_front import cdu_pkg::*; #(
   parameter int WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   cdu_req_if.sink             req,
   input  logic                queue_full,
   output logic                push,
   output logic [2*WIDTH-1:0]  num_re,
   output logic [2*WIDTH-1:0]  num_im,
   output logic [2*WIDTH-1:0]  den,
   output logic                neg_re,
   output logic                neg_im,
   output logic                div_zero
);
   localparam int NW = 2 * WIDTH;

   logic                 advance;
   logic                 s1_valid_ff, s1_valid_in;
   logic signed [NW-1:0] p_arbr_ff, p_aibi_ff, p_aibr_ff, p_arbi_ff, p_brbr_ff, p_bibi_ff;
   logic                 s2_valid_ff, s2_valid_in;
   logic signed [NW:0]   sum_re, sum_im;
   logic [NW:0]          abs_re, abs_im, den_sum;
   logic [NW-1:0]        num_re_ff, num_im_ff, den_ff;
   logic                 neg_re_ff, neg_im_ff, dz_ff;

   assign advance     = !(s2_valid_ff && queue_full);
   assign req.ready   = advance;
   assign s1_valid_in = req.valid;
   assign s2_valid_in = s1_valid_ff;

   assign sum_re  = (NW+1)'(p_arbr_ff) + (NW+1)'(p_aibi_ff);
   assign sum_im  = (NW+1)'(p_aibr_ff) - (NW+1)'(p_arbi_ff);
   assign abs_re  = sum_re[NW] ? (NW+1)'(-sum_re) : (NW+1)'(sum_re);
   assign abs_im  = sum_im[NW] ? (NW+1)'(-sum_im) : (NW+1)'(sum_im);
   assign den_sum = (NW+1)'($unsigned(p_brbr_ff)) + (NW+1)'($unsigned(p_bibi_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (advance) begin
         p_arbr_ff <= req.dividend_real * req.divisor_real;
         p_aibi_ff <= req.dividend_imag * req.divisor_imag;
         p_aibr_ff <= req.dividend_imag * req.divisor_real;
         p_arbi_ff <= req.dividend_real * req.divisor_imag;
         p_brbr_ff <= req.divisor_real * req.divisor_real;
         p_bibi_ff <= req.divisor_imag * req.divisor_imag;
         num_re_ff <= abs_re[NW-1:0];
         num_im_ff <= abs_im[NW-1:0];
         den_ff    <= den_sum[NW-1:0];
         neg_re_ff <= sum_re[NW];
         neg_im_ff <= sum_im[NW];
         dz_ff     <= (den_sum == '0);
      end
   end

   assign push     = s2_valid_ff && !queue_full;
   assign num_re   = num_re_ff;
   assign num_im   = num_im_ff;
   assign den      = den_ff;
   assign neg_re   = neg_re_ff;
   assign neg_im   = neg_im_ff;
   assign div_zero = dz_ff;
endmodule

// ===== hw/rtl/cdu_queue.sv =====
// Small queue between the front end and the divider.
module cdu_queue import cdu_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] pop_data
);
   localparam int AW = $clog2(CDU_QUEUE_DEPTH);

   logic [DATA_W-1:0] mem [CDU_QUEUE_DEPTH];
   logic [AW-1:0]     wr_ff, rd_ff;
   logic [AW:0]       count_ff;

   assign full      = (count_ff == (AW+1)'(CDU_QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + AW'(1);
         if (pop) rd_ff <= rd_ff + AW'(1);
         count_ff <= count_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem[wr_ff] <= push_data;
   end
endmodule

// ===== hw/rtl/cdu_back.sv =====
// Back end: pipelined restoring division of both parts, saturation and output register.
module cdu_back import cdu_pkg::*; #(
   parameter int WIDTH     = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   output logic               pop,
   input  logic [2*WIDTH-1:0] num_re,
   input  logic [2*WIDTH-1:0] num_im,
   input  logic [2*WIDTH-1:0] den,
   input  logic               neg_re,
   input  logic               neg_im,
   input  logic               div_zero,
   cdu_rsp_if.source          rsp
);
   localparam int NW = 2 * WIDTH;
   localparam int NB = NW + FRAC_BITS;
   localparam int QW = WIDTH + 2;

   function automatic logic [NW+QW:0] div_step(input logic [NW-1:0] rem,
                                                input logic bit_in,
                                                input logic [NW-1:0] dv,
                                                input logic [QW-1:0] q,
                                                input logic big,
                                                input logic neg);
      logic [NW:0]   sh;
      logic          take;
      logic [NW:0]   diff;
      logic [QW-1:0] qn;
      logic [QW-1:0] lim;
      logic          bign;
      sh   = {rem, bit_in};
      take = (sh >= {1'b0, dv});
      diff = take ? (sh - {1'b0, dv}) : sh;
      lim  = neg ? (QW'(1) << (WIDTH-1)) : ((QW'(1) << (WIDTH-1)) - QW'(1));
      qn   = big ? q : {q[QW-2:0], take};
      bign = big | (qn > lim);
      return {diff[NW-1:0], qn, bign};
   endfunction

   logic          en;
   logic          v_ff [NB];
   logic [NW-1:0] nr_ff [NB], ni_ff [NB], d_ff [NB], rr_ff [NB], ri_ff [NB];
   logic [QW-1:0] qr_ff [NB], qi_ff [NB];
   logic          br_ff [NB], bi_ff [NB], sr_ff [NB], si_ff [NB], z_ff [NB];

   logic                    out_valid_ff;
   logic signed [WIDTH-1:0] out_re_ff, out_im_ff, res_re, res_im;
   logic [1:0]              out_status_ff, status_in;
   logic [QW-1:0]           mag_re, mag_im;

   assign en  = !out_valid_ff || rsp.ready;
   assign pop = en && not_empty;

   for (genvar k = 0; k < NB; k++) begin : g_stage
      logic          v_src;
      logic [NW-1:0] nr_src, ni_src, d_src, rr_src, ri_src;
      logic [QW-1:0] qr_src, qi_src;
      logic          br_src, bi_src, sr_src, si_src, z_src;
      logic [NW+QW:0] step_re, step_im;
      if (k == 0) begin : g_head
         assign v_src  = not_empty;
         assign nr_src = num_re;
         assign ni_src = num_im;
         assign d_src  = den;
         assign rr_src = '0;
         assign ri_src = '0;
         assign qr_src = '0;
         assign qi_src = '0;
         assign br_src = 1'b0;
         assign bi_src = 1'b0;
         assign sr_src = neg_re;
         assign si_src = neg_im;
         assign z_src  = div_zero;
      end else begin : g_body
         assign v_src  = v_ff[k-1];
         assign nr_src = nr_ff[k-1];
         assign ni_src = ni_ff[k-1];
         assign d_src  = d_ff[k-1];
         assign rr_src = rr_ff[k-1];
         assign ri_src = ri_ff[k-1];
         assign qr_src = qr_ff[k-1];
         assign qi_src = qi_ff[k-1];
         assign br_src = br_ff[k-1];
         assign bi_src = bi_ff[k-1];
         assign sr_src = sr_ff[k-1];
         assign si_src = si_ff[k-1];
         assign z_src  = z_ff[k-1];
      end
      assign step_re = div_step(rr_src, nr_src[NW-1], d_src, qr_src, br_src, sr_src);
      assign step_im = div_step(ri_src, ni_src[NW-1], d_src, qi_src, bi_src, si_src);
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
         if (en) begin
            nr_ff[k] <= {nr_src[NW-2:0], 1'b0};
            ni_ff[k] <= {ni_src[NW-2:0], 1'b0};
            d_ff[k]  <= d_src;
            rr_ff[k] <= step_re[NW+QW:QW+1];
            ri_ff[k] <= step_im[NW+QW:QW+1];
            qr_ff[k] <= step_re[QW:1];
            qi_ff[k] <= step_im[QW:1];
            br_ff[k] <= step_re[0];
            bi_ff[k] <= step_im[0];
            sr_ff[k] <= sr_src;
            si_ff[k] <= si_src;
            z_ff[k]  <= z_src;
         end
      end
   end

   assign mag_re = br_ff[NB-1] ? (sr_ff[NB-1] ? (QW'(1) << (WIDTH-1))
                                              : ((QW'(1) << (WIDTH-1)) - QW'(1)))
                               : qr_ff[NB-1];
   assign mag_im = bi_ff[NB-1] ? (si_ff[NB-1] ? (QW'(1) << (WIDTH-1))
                                              : ((QW'(1) << (WIDTH-1)) - QW'(1)))
                               : qi_ff[NB-1];
   assign res_re = sr_ff[NB-1] ? WIDTH'(-mag_re) : WIDTH'(mag_re);
   assign res_im = si_ff[NB-1] ? WIDTH'(-mag_im) : WIDTH'(mag_im);

   always_comb begin
      priority if (z_ff[NB-1]) begin
         status_in = CDU_STATUS_DIVZ;
      end else if (br_ff[NB-1] || bi_ff[NB-1]) begin
         status_in = CDU_STATUS_OVF;
      end else begin
         status_in = CDU_STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_ff[NB-1];
      end
      if (en) begin
         out_re_ff     <= z_ff[NB-1] ? '0 : res_re;
         out_im_ff     <= z_ff[NB-1] ? '0 : res_im;
         out_status_ff <= status_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.quotient_real = out_re_ff;
   assign rsp.quotient_imag = out_im_ff;
   assign rsp.status        = out_status_ff;
endmodule

// ===== hw/rtl/complex_divide_unit.sv =====
// Top level of the complex divide unit.
// Accepts one complex division per clock unless a full queue stalls the front end, and returns
// one result per transfer, in order. A division passes the front-end product and sum registers,
// the four-entry queue, then 2*WIDTH+FRAC_BITS divider stages and one output register. The
// divider pipeline produces one quotient bit per stage for both parts; a zero divisor gives
// zero parts with status 2, saturation gives status 1.
`include "complex_divide_unit_defines.svh"
module complex_divide_unit import cdu_pkg::*; #(
   parameter int WIDTH     = 16,
   parameter int FRAC_BITS = 8
) (
   input logic       clock,
   input logic       reset,
   cdu_req_if.sink   req_ch,
   cdu_rsp_if.source rsp_ch
);
   localparam int NW = 2 * WIDTH;
   localparam int DW = 3 * NW + 3;
   localparam logic signed [WIDTH-1:0] SAT_MAX = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic signed [WIDTH-1:0] SAT_MIN = {1'b1, {(WIDTH-1){1'b0}}};

   logic          push, full, pop, not_empty;
   logic [NW-1:0] f_num_re, f_num_im, f_den;
   logic          f_neg_re, f_neg_im, f_dz;
   logic [DW-1:0] q_in, q_out;

   cdu_front #(.WIDTH(WIDTH)) u_front (
      .clock(clock), .reset(reset), .req(req_ch), .queue_full(full), .push(push),
      .num_re(f_num_re), .num_im(f_num_im), .den(f_den),
      .neg_re(f_neg_re), .neg_im(f_neg_im), .div_zero(f_dz)
   );

   assign q_in = {f_num_re, f_num_im, f_den, f_neg_re, f_neg_im, f_dz};

   cdu_queue #(.DATA_W(DW)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(q_in), .full(full),
      .pop(pop), .not_empty(not_empty), .pop_data(q_out)
   );

   cdu_back #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .not_empty(not_empty), .pop(pop),
      .num_re(q_out[DW-1 -: NW]), .num_im(q_out[DW-1-NW -: NW]),
      .den(q_out[3 +: NW]), .neg_re(q_out[2]), .neg_im(q_out[1]), .div_zero(q_out[0]),
      .rsp(rsp_ch)
   );

   `CDU_ASSERT(a_divz_zero, clock, reset, (rsp_ch.valid && rsp_ch.status == CDU_STATUS_DIVZ) |-> (rsp_ch.quotient_real == '0 && rsp_ch.quotient_imag == '0))
   `CDU_ASSERT(a_ovf_sat, clock, reset, (rsp_ch.valid && rsp_ch.status == CDU_STATUS_OVF) |-> (rsp_ch.quotient_real == SAT_MAX || rsp_ch.quotient_real == SAT_MIN || rsp_ch.quotient_imag == SAT_MAX || rsp_ch.quotient_imag == SAT_MIN))
   `CDU_NEVER(a_push_full, clock, reset, push && full)
endmodule

// ===== tb/complex_divide_unit_tb_if.sv =====
// Testbench constants used by the testbench.
`timescale 1ns / 1ps
package complex_divide_unit_tb_pkg;
   localparam int TB_WIDTH = 16;
   localparam int TB_FRAC  = 8;
endpackage

// ===== tb/complex_divide_unit_tb.sv =====
// Testbench of the complex divide unit: directed and random divisions checked in order.
`timescale 1ns / 1ps
module complex_divide_unit_tb;
   import cdu_pkg::*;
   import complex_divide_unit_tb_pkg::*;

   localparam int W = TB_WIDTH;
   localparam int F = TB_FRAC;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic signed [W-1:0] qr;
      logic signed [W-1:0] qi;
      logic [1:0]          st;
   } quotient_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   cdu_req_if #(.WIDTH(W)) req_ch ();
   cdu_rsp_if #(.WIDTH(W)) rsp_ch ();

   complex_divide_unit #(.WIDTH(W), .FRAC_BITS(F)) uut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   quotient_type pending_quotients[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 1'b0;
   int idle_cycles = 0;
   int n_sent = 0;
   int n_ovf = 0;
   int n_divz = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.dividend_real = '0;
      req_ch.dividend_imag = '0;
      req_ch.divisor_real = '0;
      req_ch.divisor_imag = '0;
      rsp_ch.ready = 1'b0;
   end

   // Divides (num << F) by den on magnitudes and saturates to the signed range.
   function automatic logic [W-1:0] divide_part(bit neg, logic [63:0] num, logic [63:0] den,
                                                inout bit ovf);
      logic [127:0] q;
      logic [63:0] lim;
      lim = neg ? (64'd1 << (W-1)) : ((64'd1 << (W-1)) - 64'd1);
      q = ({64'd0, num} << F) / {64'd0, den};
      if (q > {64'd0, lim}) begin
         ovf = 1'b1;
         q = {64'd0, lim};
      end
      return neg ? W'(-q[W-1:0]) : q[W-1:0];
   endfunction

   function automatic quotient_type predict_quotient(logic signed [W-1:0] ar,
                                                     logic signed [W-1:0] ai,
                                                     logic signed [W-1:0] br,
                                                     logic signed [W-1:0] bi);
      quotient_type r;
      longint sre, sim, den;
      bit ovf;
      ovf = 1'b0;
      den = longint'(br) * br + longint'(bi) * bi;
      if (den == 0) begin
         r.qr = '0;
         r.qi = '0;
         r.st = CDU_STATUS_DIVZ;
         return r;
      end
      sre = longint'(ar) * br + longint'(ai) * bi;
      sim = longint'(ai) * br - longint'(ar) * bi;
      r.qr = divide_part(sre < 0, sre < 0 ? -sre : sre, den, ovf);
      r.qi = divide_part(sim < 0, sim < 0 ? -sim : sim, den, ovf);
      r.st = ovf ? CDU_STATUS_OVF : CDU_STATUS_OK;
      return r;
   endfunction

   task automatic send_division(logic [W-1:0] ar, logic [W-1:0] ai,
                                logic [W-1:0] br, logic [W-1:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.dividend_real <= ar;
      req_ch.dividend_imag <= ai;
      req_ch.divisor_real <= br;
      req_ch.divisor_imag <= bi;
      pending_quotients.push_back(predict_quotient(ar, ai, br, bi));
      n_sent++;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      quotient_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_quotients.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            want = pending_quotients.pop_front();
            if (rsp_ch.quotient_real !== want.qr) begin
               $error("quotient_real expected %0d actual %0d", want.qr, rsp_ch.quotient_real);
               errors++;
            end
            if (rsp_ch.quotient_imag !== want.qi) begin
               $error("quotient_imag expected %0d actual %0d", want.qi, rsp_ch.quotient_imag);
               errors++;
            end
            if (rsp_ch.status !== want.st) begin
               $error("status expected %0d actual %0d", want.st, rsp_ch.status);
               errors++;
            end
            if (want.st == CDU_STATUS_OVF) n_ovf++;
            if (want.st == CDU_STATUS_DIVZ) n_divz++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [W-1:0] random_field();
      case ($urandom_range(3))
         0: return W'($urandom);
         1: return W'($signed($urandom_range(1024)) - 512);
         2: return $urandom_range(1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         default: return W'($signed($urandom_range(64)) - 32) << F;
      endcase
   endfunction

   task automatic test_directed();
      logic [W-1:0] mx, mn, one;
      mx = {1'b0, {(W-1){1'b1}}};
      mn = {1'b1, {(W-1){1'b0}}};
      one = W'(1) << F;
      send_division(one, one, '0, '0);
      send_division('0, '0, '0, '0);
      send_division(mx, mn, '0, '0);
      send_division(one, '0, one, '0);
      send_division(one, one, one, one);
      send_division(mx, mx, 16'd1, '0);
      send_division(mn, mn, 16'd1, '0);
      send_division(mn, '0, 16'hFFFF, '0);
      send_division(mx, mn, mx, mn);
      send_division(mn, mn, mn, mn);
      send_division(mn, mx, mn, '0);
      send_division('0, mn, '0, mn);
      send_division(16'h0300, 16'hFD00, 16'h0100, 16'hFF00);
      send_division(16'hFFFF, 16'h0001, mx, mx);
      send_division(16'h0001, '0, mn, mn);
      send_division(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         send_division(random_field(), random_field(), random_field(),
                       $urandom_range(15) == 0 ? '0 : random_field());
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         test_random(100);
         begin
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
      join
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_quotients.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 34;
      recv_idle_pct = 63;
      test_directed();
      test_random(200);
      send_idle_pct = 63;
      recv_idle_pct = 34;
      test_random(200);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(90);
      drain();
      $display("Sent %0d divisions, %0d saturated and %0d with a zero divisor.",
               n_sent, n_ovf, n_divz);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
